// ===== rtl/core/smpq_pkg.sv =====
// shared types and constants for the sorted minimum priority queue
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int DATA_W           = 32;
  localparam int COUNT_W          = 5;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // operation broadcast to every cell in the row
  typedef struct packed {
    logic push;
    logic pop;
  } smpq_op_t;

endpackage

// ===== rtl/core/smpq_cell.sv =====
// one storage cell of the sorted row: compare against the pushed value and shift
`timescale 1ns / 1ps

module smpq_cell (
  input  logic                                  clk,
  input  smpq_pkg::smpq_op_t                    op,
  input  logic signed [smpq_pkg::DATA_W-1:0]    ins_value,
  input  logic                                  occupied,
  input  logic                                  prev_lt,
  input  logic signed [smpq_pkg::DATA_W-1:0]    prev_value,
  input  logic signed [smpq_pkg::DATA_W-1:0]    next_value,
  output logic signed [smpq_pkg::DATA_W-1:0]    value,
  output logic                                  lt
);

  logic signed [smpq_pkg::DATA_W-1:0] value_r;
  logic signed [smpq_pkg::DATA_W-1:0] value_nxt;

  // stored value sits ahead of the pushed one
  assign lt    = occupied && (value_r < ins_value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (op.push) begin
      if (lt) begin
        value_nxt = value_r;
      end else if (prev_lt) begin
        value_nxt = ins_value;
      end else begin
        value_nxt = prev_value;
      end
    end else if (op.pop) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== rtl/core/sorted_min_priority_queue.sv =====
// top level of the sorted minimum priority queue: cell row, count and result register
`timescale 1ns / 1ps

// Bounded min priority queue of signed 32-bit values held in ascending order in a
// row of CAPACITY cells. Every cell compares its entry with a pushed value in
// parallel and on a push keeps it, takes the new value or takes its left neighbor's;
// on a pop it takes its right neighbor's. One transaction is taken every cycle
// unless the input stalls. Each transaction gives one result in the next cycle from
// the result register; the input stalls only while that result is held by a stalled
// output. A push into a full queue is dropped and flagged; a pop of an empty queue
// is ignored. smallest reads -2147483648 while the queue is empty.

module sorted_min_priority_queue #(
  parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_command,
  input  logic signed [smpq_pkg::DATA_W-1:0]    in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [smpq_pkg::DATA_W-1:0]    out_smallest,
  output logic                                  out_is_empty,
  output logic [smpq_pkg::COUNT_W-1:0]          out_count,
  output logic                                  out_push_dropped
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                                 in_accept;
  logic                                 full;
  logic                                 empty;
  smpq_pkg::smpq_op_t                   op;
  logic [CNT_W-1:0]                     count_r;
  logic [CNT_W-1:0]                     count_nxt;
  logic                                 out_valid_r;
  logic                                 dropped_r;
  logic signed [smpq_pkg::DATA_W-1:0]   cell_value [CAPACITY];
  logic [CAPACITY-1:0]                  cell_lt;
  logic [CAPACITY-1:0]                  cell_occ;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CAP_CNT);
  assign empty     = (count_r == '0);

  assign op.push = in_accept && (in_command == smpq_pkg::CMD_PUSH) && !full;
  assign op.pop  = in_accept && (in_command == smpq_pkg::CMD_POP) && !empty;

  always_comb begin
    count_nxt = count_r;
    if (op.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                               p_lt;
      logic signed [smpq_pkg::DATA_W-1:0] p_val;
      logic signed [smpq_pkg::DATA_W-1:0] n_val;

      assign cell_occ[gi] = (CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_first
        // the head always takes the value when nothing is ahead of it
        assign p_lt  = 1'b1;
        assign p_val = in_value;
      end else begin : g_mid
        assign p_lt  = cell_lt[gi-1];
        assign p_val = cell_value[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign n_val = cell_value[gi];
      end else begin : g_inner
        assign n_val = cell_value[gi+1];
      end

      smpq_cell u_cell (
        .clk        (clk),
        .op         (op),
        .ins_value  (in_value),
        .occupied   (cell_occ[gi]),
        .prev_lt    (p_lt),
        .prev_value (p_val),
        .next_value (n_val),
        .value      (cell_value[gi]),
        .lt         (cell_lt[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dropped_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
        dropped_r   <= (in_command == smpq_pkg::CMD_PUSH) && full;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // state only moves on a transaction, so the cells hold the last result
  assign out_valid        = out_valid_r;
  assign out_is_empty     = empty;
  assign out_smallest     = empty ? smpq_pkg::INT_MIN : cell_value[0];
  assign out_push_dropped = dropped_r;

  generate
    if (CNT_W >= smpq_pkg::COUNT_W) begin : g_cnt_trunc
      assign out_count = count_r[smpq_pkg::COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign out_count = {{(smpq_pkg::COUNT_W-CNT_W){1'b0}}, count_r};
    end
  endgenerate

endmodule

// ===== rtl/core/smpq_checker.sv =====
// port-level checks for the sorted minimum priority queue, bound to the top level
`timescale 1ns / 1ps

module smpq_checker #(
  parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [smpq_pkg::DATA_W-1:0]   out_smallest,
  input logic                                 out_is_empty,
  input logic [smpq_pkg::COUNT_W-1:0]         out_count,
  input logic                                 out_push_dropped
);

  localparam logic [smpq_pkg::COUNT_W-1:0] CAP_OUT = smpq_pkg::COUNT_W'(CAPACITY);

  // every accepted transaction shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result after accepted transaction");

  // an empty queue reports the minimum value
  a_empty_smallest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_smallest == smpq_pkg::INT_MIN))
    else $error("empty queue shows a stored value");

  // a dropped push only happens on a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_push_dropped) |-> (out_count == CAP_OUT && !out_is_empty))
    else $error("push dropped while not full");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_smallest) && $stable(out_count)
       && $stable(out_push_dropped)))
    else $error("stalled result changed");

endmodule

bind sorted_min_priority_queue smpq_checker #(.CAPACITY(CAPACITY)) u_smpq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_smallest     (out_smallest),
  .out_is_empty     (out_is_empty),
  .out_count        (out_count),
  .out_push_dropped (out_push_dropped)
);
